// ===== src/hue_sweep_rgb_led_driver_unit_assert.svh =====
// ----------------------------------------------------------------------------
// hue sweep led driver assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef HUE_SWEEP_RGB_LED_DRIVER_UNIT_ASSERT_SVH
`define HUE_SWEEP_RGB_LED_DRIVER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define HSRGB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define HSRGB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define HSRGB_ASSERT_NXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hsrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsrgb_pkg
// widths, codes and types shared by the hue sweep led driver
// ----------------------------------------------------------------------------
package hsrgb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DUTY_BITS  = 10;

  localparam int SECTORS    = 6;
  localparam int SEC_W      = 3;
  localparam int STEP_W     = 16;
  localparam int BRIGHT_W   = 10;
  localparam int OUT_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int HUE_W    = SEC_W + FRAC_BITS;
  localparam int SUM_W    = ((HUE_W > STEP_W) ? HUE_W : STEP_W) + 1;
  localparam int DUTY_MAX = (2 ** DUTY_BITS) - 1;
  localparam int SAT_W    = (DUTY_BITS > BRIGHT_W) ? DUTY_BITS : BRIGHT_W;
  localparam int PROD_W   = FRAC_BITS + DUTY_BITS;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HUE_STEP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0]   HUE_STEP_RST = STEP_W'(37);
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST   = BRIGHT_W'(60);

  localparam logic [SUM_W-1:0] FULL_CIRCLE = SUM_W'(SECTORS) << FRAC_BITS;

  // sector codes, named after the hue at the start of the sector
  localparam logic [SEC_W-1:0] SEC_RED     = SEC_W'(0);
  localparam logic [SEC_W-1:0] SEC_YELLOW  = SEC_W'(1);
  localparam logic [SEC_W-1:0] SEC_GREEN   = SEC_W'(2);
  localparam logic [SEC_W-1:0] SEC_CYAN    = SEC_W'(3);
  localparam logic [SEC_W-1:0] SEC_BLUE    = SEC_W'(4);
  localparam logic [SEC_W-1:0] SEC_MAGENTA = SEC_W'(5);

  typedef struct packed {
    logic [SEC_W-1:0]     sector;
    logic [FRAC_BITS-1:0] frac;
    logic [DUTY_BITS-1:0] bright;
  } hue_item_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_stat_t;

endpackage

// ===== src/hue_sweep_rgb_led_driver_unit.sv =====
// ----------------------------------------------------------------------------
// hue_sweep_rgb_led_driver_unit
// hue sweep to full-saturation rgb pwm duty values
// ----------------------------------------------------------------------------
// Each accepted item advances the hue by hue_step (when advance is set) and
// returns one result: red, green and blue pwm compare values at the
// configured brightness plus the sector of the hue after the step. The block
// takes one item every cycle while the queue has room; an item is written
// into the queue and, once popped, into the output register. The front holds
// the hue accumulator add and compare, the back the single fraction times
// brightness multiply. A two-entry queue sits between the two, so the input
// keeps taking two more items while a result waits on out_ready. The user
// must write configuration through cfg_we, cfg_index and cfg_wdata only while
// the block is idle (left to the user); hue_step resets to 37, brightness to 60.
module hue_sweep_rgb_led_driver_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [hsrgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsrgb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // tick items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_advance,
  // duty results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [hsrgb_pkg::OUT_W-1:0]          out_red_duty,
  output logic [hsrgb_pkg::OUT_W-1:0]          out_green_duty,
  output logic [hsrgb_pkg::OUT_W-1:0]          out_blue_duty,
  output logic [hsrgb_pkg::SEC_W-1:0]          out_hue_sector
);

  // queue status and handshake between front and back
  hsrgb_pkg::q_stat_t   q_stat;
  hsrgb_pkg::hue_item_t push_item;
  hsrgb_pkg::hue_item_t head_item;
  logic                 push;
  logic                 pop;

  // front: config, hue accumulator, builds one item per tick
  hsrgb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_advance (in_advance),
    .q_stat     (q_stat),
    .push       (push),
    .push_item  (push_item)
  );

  // decoupling queue
  hsrgb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  // back: rise and fall multiply, channel select, output register
  hsrgb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_duty   (out_red_duty),
    .out_green_duty (out_green_duty),
    .out_blue_duty  (out_blue_duty),
    .out_hue_sector (out_hue_sector)
  );

endmodule

// ===== src/hsrgb_queue.sv =====
// ----------------------------------------------------------------------------
// hsrgb_queue
// short fifo of classified hue items between front and back
// ----------------------------------------------------------------------------
module hsrgb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hsrgb_pkg::hue_item_t push_item,
  input  logic                 pop,
  output hsrgb_pkg::hue_item_t head_item,
  output hsrgb_pkg::q_stat_t   stat
);

  hsrgb_pkg::hue_item_t                 mem_r [hsrgb_pkg::Q_DEPTH];
  logic [hsrgb_pkg::Q_PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [hsrgb_pkg::Q_PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [hsrgb_pkg::Q_CNT_W-1:0]        count_r, count_nxt;
  logic                                 do_push, do_pop;

  assign stat.not_empty = (count_r != '0);
  assign stat.not_full  = (count_r != hsrgb_pkg::Q_CNT_W'(hsrgb_pkg::Q_DEPTH));
  assign do_push = push && stat.not_full;
  assign do_pop  = pop && stat.not_empty;
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == hsrgb_pkg::Q_PTR_W'(hsrgb_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == hsrgb_pkg::Q_PTR_W'(hsrgb_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/hsrgb_front.sv =====
// ----------------------------------------------------------------------------
// hsrgb_front
// config registers, hue accumulator and item classification
// ----------------------------------------------------------------------------
module hsrgb_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hsrgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsrgb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_advance,
  input  hsrgb_pkg::q_stat_t                   q_stat,
  output logic                                 push,
  output hsrgb_pkg::hue_item_t                 push_item
);

  logic [hsrgb_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [hsrgb_pkg::BRIGHT_W-1:0]  bright_r, bright_nxt;
  logic [hsrgb_pkg::HUE_W-1:0]     hue_r, hue_nxt;
  logic [hsrgb_pkg::SUM_W-1:0]     sum;
  logic [hsrgb_pkg::HUE_W-1:0]     hue_adv;
  logic [hsrgb_pkg::SAT_W-1:0]     br_ext;
  logic [hsrgb_pkg::DUTY_BITS-1:0] bright_sat;

  assign in_ready = q_stat.not_full;
  assign push     = in_valid && in_ready;

  // add step, full circle or beyond wraps to exactly zero
  assign sum     = hsrgb_pkg::SUM_W'(hue_r) + hsrgb_pkg::SUM_W'(step_r);
  assign hue_adv = (sum >= hsrgb_pkg::FULL_CIRCLE) ? '0 : sum[hsrgb_pkg::HUE_W-1:0];

  always_comb begin
    hue_nxt = hue_r;
    if (push && in_advance) begin
      hue_nxt = hue_adv;
    end
  end

  // brightness saturates at full duty
  assign br_ext     = hsrgb_pkg::SAT_W'(bright_r);
  assign bright_sat = (br_ext > hsrgb_pkg::SAT_W'(hsrgb_pkg::DUTY_MAX)) ?
                      hsrgb_pkg::DUTY_BITS'(hsrgb_pkg::DUTY_MAX) :
                      hsrgb_pkg::DUTY_BITS'(br_ext);

  // item carries the hue after this step, or the held hue without advance
  always_comb begin
    push_item.sector = in_advance ? hue_adv[hsrgb_pkg::HUE_W-1:hsrgb_pkg::FRAC_BITS] :
                                    hue_r[hsrgb_pkg::HUE_W-1:hsrgb_pkg::FRAC_BITS];
    push_item.frac   = in_advance ? hue_adv[hsrgb_pkg::FRAC_BITS-1:0] :
                                    hue_r[hsrgb_pkg::FRAC_BITS-1:0];
    push_item.bright = bright_sat;
  end

  always_comb begin
    step_nxt   = step_r;
    bright_nxt = bright_r;
    if (cfg_we) begin
      case (cfg_index)
        hsrgb_pkg::REG_HUE_STEP:   step_nxt   = cfg_wdata[hsrgb_pkg::STEP_W-1:0];
        hsrgb_pkg::REG_BRIGHTNESS: bright_nxt = cfg_wdata[hsrgb_pkg::BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= hsrgb_pkg::HUE_STEP_RST;
      bright_r <= hsrgb_pkg::BRIGHT_RST;
      hue_r    <= '0;
    end else begin
      step_r   <= step_nxt;
      bright_r <= bright_nxt;
      hue_r    <= hue_nxt;
    end
  end

endmodule

// ===== src/hsrgb_back.sv =====
// ----------------------------------------------------------------------------
// hsrgb_back
// duty computation and output register
// ----------------------------------------------------------------------------
module hsrgb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsrgb_pkg::q_stat_t            q_stat,
  input  hsrgb_pkg::hue_item_t          head_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsrgb_pkg::OUT_W-1:0]   out_red_duty,
  output logic [hsrgb_pkg::OUT_W-1:0]   out_green_duty,
  output logic [hsrgb_pkg::OUT_W-1:0]   out_blue_duty,
  output logic [hsrgb_pkg::SEC_W-1:0]   out_hue_sector
);

  logic                              out_valid_r, out_valid_nxt;
  logic [hsrgb_pkg::OUT_W-1:0]       red_r, green_r, blue_r;
  logic [hsrgb_pkg::SEC_W-1:0]       sector_r;
  logic [hsrgb_pkg::PROD_W-1:0]      prod;
  logic [hsrgb_pkg::DUTY_BITS-1:0]   rise, fall, b, r, g, bl;
  logic                              rem_nz;
  logic [hsrgb_pkg::SEC_W-1:0]       sec;

  assign pop = q_stat.not_empty && (!out_valid_r || out_ready);

  // one multiply; fall = b - ceil(frac * b)
  assign b      = head_item.bright;
  assign prod   = hsrgb_pkg::PROD_W'(head_item.frac) * hsrgb_pkg::PROD_W'(b);
  assign rise   = prod[hsrgb_pkg::PROD_W-1:hsrgb_pkg::FRAC_BITS];
  assign rem_nz = |prod[hsrgb_pkg::FRAC_BITS-1:0];
  assign fall   = b - rise - hsrgb_pkg::DUTY_BITS'(rem_nz);

  always_comb begin
    sec = head_item.sector;
    r   = b;
    g   = rise;
    bl  = '0;
    case (head_item.sector)
      hsrgb_pkg::SEC_RED: begin
        r = b;    g = rise; bl = '0;
      end
      hsrgb_pkg::SEC_YELLOW: begin
        r = fall; g = b;    bl = '0;
      end
      hsrgb_pkg::SEC_GREEN: begin
        r = '0;   g = b;    bl = rise;
      end
      hsrgb_pkg::SEC_CYAN: begin
        r = '0;   g = fall; bl = b;
      end
      hsrgb_pkg::SEC_BLUE: begin
        r = rise; g = '0;   bl = b;
      end
      hsrgb_pkg::SEC_MAGENTA: begin
        r = b;    g = '0;   bl = fall;
      end
      default: begin
        sec = hsrgb_pkg::SEC_RED;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      red_r    <= hsrgb_pkg::OUT_W'(r);
      green_r  <= hsrgb_pkg::OUT_W'(g);
      blue_r   <= hsrgb_pkg::OUT_W'(bl);
      sector_r <= sec;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_duty   = red_r;
  assign out_green_duty = green_r;
  assign out_blue_duty  = blue_r;
  assign out_hue_sector = sector_r;

endmodule

// ===== src/hue_sweep_rgb_led_driver_unit_chk.sv =====
// ----------------------------------------------------------------------------
// hue_sweep_rgb_led_driver_unit_chk
// port-level checks on the hue sweep led driver
// ----------------------------------------------------------------------------
`include "hue_sweep_rgb_led_driver_unit_assert.svh"

module hue_sweep_rgb_led_driver_unit_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 cfg_we,
  input logic [hsrgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [hsrgb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_advance,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [hsrgb_pkg::OUT_W-1:0]          out_red_duty,
  input logic [hsrgb_pkg::OUT_W-1:0]          out_green_duty,
  input logic [hsrgb_pkg::OUT_W-1:0]          out_blue_duty,
  input logic [hsrgb_pkg::SEC_W-1:0]          out_hue_sector
);

  // a stalled result stays offered
  `HSRGB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // sector codes six and seven never leave the block
  `HSRGB_ASSERT_IMP(a_sector_range, out_valid, (out_hue_sector != 3'd6) && (out_hue_sector != 3'd7), "sector out of range")

  // full saturation: one channel is always off
  `HSRGB_ASSERT_IMP(a_one_off, out_valid, (out_red_duty == '0) || (out_green_duty == '0) || (out_blue_duty == '0), "no channel off")

  // reset leaves an empty output and an open input
  `HSRGB_ASSERT_NXT_ALWAYS(a_reset_clear, !rst_n, !out_valid && in_ready, "not clear after reset")

endmodule

bind hue_sweep_rgb_led_driver_unit hue_sweep_rgb_led_driver_unit_chk u_chk (.*);
